// ===== rtl/bdad_pkg.sv =====
// shared types and constants for the binary to decimal ascii converter
package bdad_pkg;

	localparam int VALUE_W    = 27;
	localparam int IN_DATA_W  = 32;
	localparam int CHAR_W     = 6;
	localparam int OUT_DATA_W = 8;
	localparam int DIGIT_W    = 4;
	// a 27-bit value never needs more than nine decimal digits
	localparam int BCD_DIGITS = 9;
	localparam int IDX_W      = $clog2(BCD_DIGITS);
	localparam int CNT_W      = $clog2(VALUE_W);
	localparam int MAX_DIGITS = 8;

	localparam longint unsigned DIGIT_LIMIT = 64'd10 ** MAX_DIGITS;
	localparam logic [CHAR_W-1:0] ASCII_ZERO = 6'd48;

	typedef logic [BCD_DIGITS-1:0][DIGIT_W-1:0] bcd_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_CONVERT,
		ST_SCAN,
		ST_EMIT
	} state_t;

endpackage

// ===== rtl/bdad_dabble.sv =====
// one shift-add-3 step of the double dabble conversion
module bdad_dabble
	import bdad_pkg::*;
(
	input  bcd_t bcd_in,
	input  logic bit_in,
	output bcd_t bcd_out
);

	bcd_t adj;

	always_comb begin
		for (int i = 0; i < BCD_DIGITS; i++) begin
			if (bcd_in[i] >= DIGIT_W'(5)) begin
				adj[i] = bcd_in[i] + DIGIT_W'(3);
			end else begin
				adj[i] = bcd_in[i];
			end
		end
	end

	assign bcd_out = bcd_t'({adj, bit_in});

endmodule

// ===== rtl/binary_to_decimal_ascii_digits.sv =====
// top level: sequencer, shared double dabble step and digit output register
// each request is accepted, then shifted one value bit at a time through the shared dabble step,
// then leading zeros are skipped and one digit at a time is sent, held while the receiver stalls
// a new request is taken only in idle, after the last digit of the previous one is loaded for output
// an overflow request skips the conversion and sends its single result at once
// arst_n clears the sequencer and the output valid; the datapath is not reset
module binary_to_decimal_ascii_digits
	import bdad_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	// input request
	input  logic                  s_tvalid,
	output logic                  s_tready,
	input  logic [IN_DATA_W-1:0]  s_tdata,   // [26:0] value, [31:27] zero
	// output result
	output logic                  m_tvalid,
	input  logic                  m_tready,
	output logic [OUT_DATA_W-1:0] m_tdata,   // [5:0] digit_char, [7:6] zero
	output logic                  m_tlast,
	output logic [0:0]            m_tuser    // [0] overflow
);

	state_t state_q, state_d;

	logic [VALUE_W-1:0] sh_q;
	bcd_t               bcd_q;
	bcd_t               bcd_step;
	logic [CNT_W-1:0]   cnt_q;
	logic [IDX_W-1:0]   idx_q;
	logic               ovf_q;

	logic [CHAR_W-1:0]  char_q;
	logic               last_q;
	logic               ovf_out_q;
	logic               out_valid_q;

	// control from the output decode
	logic in_accept;
	logic in_ovf;
	logic slot_free;
	logic load_out;
	logic cur_zero;

	// shared step unit, fed from the msb of the shift register
	bdad_dabble u_dabble (
		.bcd_in  (bcd_q),
		.bit_in  (sh_q[VALUE_W-1]),
		.bcd_out (bcd_step)
	);

	assign in_ovf   = {{(64-VALUE_W){1'b0}}, s_tdata[VALUE_W-1:0]} >= DIGIT_LIMIT;
	assign cur_zero = (bcd_q[idx_q] == '0);

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (s_tvalid) begin
					state_d = in_ovf ? ST_EMIT : ST_CONVERT;
				end
			end
			ST_CONVERT: begin
				if (cnt_q == CNT_W'(VALUE_W - 1)) begin
					state_d = ST_SCAN;
				end
			end
			ST_SCAN: begin
				// drop leading zeros, always keep the units digit
				if (idx_q == '0 || !cur_zero) begin
					state_d = ST_EMIT;
				end
			end
			ST_EMIT: begin
				if (slot_free && idx_q == '0) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// outputs of the sequencer
	always_comb begin
		s_tready  = 1'b0;
		load_out  = 1'b0;
		slot_free = !out_valid_q || m_tready;
		case (state_q)
			ST_IDLE:    s_tready = 1'b1;
			ST_CONVERT: s_tready = 1'b0;
			ST_SCAN:    s_tready = 1'b0;
			ST_EMIT:    load_out = slot_free;
			default:    s_tready = 1'b0;
		endcase
		in_accept = s_tready && s_tvalid;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (load_out) begin
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// conversion datapath
	always_ff @(posedge clk) begin
		if (in_accept) begin
			sh_q  <= s_tdata[VALUE_W-1:0];
			bcd_q <= '0;
			cnt_q <= '0;
			ovf_q <= in_ovf;
			idx_q <= '0;
		end else begin
			case (state_q)
				ST_CONVERT: begin
					bcd_q <= bcd_step;
					sh_q  <= {sh_q[VALUE_W-2:0], 1'b0};
					cnt_q <= cnt_q + CNT_W'(1);
					idx_q <= IDX_W'(BCD_DIGITS - 1);
				end
				ST_SCAN: begin
					if (idx_q != '0 && cur_zero) begin
						idx_q <= idx_q - IDX_W'(1);
					end
				end
				ST_EMIT: begin
					if (slot_free && idx_q != '0) begin
						idx_q <= idx_q - IDX_W'(1);
					end
				end
				default: idx_q <= idx_q;
			endcase
		end
	end

	// output register, parts the result side from the sequencer
	always_ff @(posedge clk) begin
		if (load_out) begin
			if (ovf_q) begin
				char_q <= '0;
			end else begin
				char_q <= ASCII_ZERO + {{(CHAR_W-DIGIT_W){1'b0}}, bcd_q[idx_q]};
			end
			last_q    <= (idx_q == '0);
			ovf_out_q <= ovf_q;
		end
	end

	assign m_tvalid   = out_valid_q;
	assign m_tdata    = {{(OUT_DATA_W-CHAR_W){1'b0}}, char_q};
	assign m_tlast    = last_q;
	assign m_tuser[0] = ovf_out_q;

endmodule
